// ===== hdl/deg_pkg.sv =====
// Shared constants and types for the diagonal emboss gray filter.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package deg_pkg;

    localparam int MAX_WIDTH = 4096;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = 16;
    localparam int F_W       = 6;               // depth / 10 for a 9-bit depth
    localparam int SUM_W     = 16;
    localparam int NJOB      = 4;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);

    localparam int DEPTH_RESET  = 30;
    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;

    // configuration register indexes
    localparam logic [1:0] REG_DEPTH  = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    // result slots released by one pixel, in release order
    localparam int JOB_UP_LEFT = 0;
    localparam int JOB_UP      = 1;
    localparam int JOB_LEFT    = 2;
    localparam int JOB_SELF    = 3;

    typedef logic [31:0] pixel_t;

    typedef struct packed {
        logic [F_W-1:0]   factor;
        logic [COL_W-1:0] col_last;
        logic [ROW_W-1:0] row_last;
    } cfg_t;

    typedef struct packed {
        pixel_t           px;
        pixel_t           up_left;
        pixel_t           up;
        pixel_t           left;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [NJOB-1:0]  mask;
    } item_t;

endpackage

// ===== hdl/deg_front.sv =====
// Front end: pixel intake, raster counters, line buffer and
// classification of the results each pixel releases. Depends on deg_pkg.
`timescale 1ns / 1ps

module deg_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  deg_pkg::cfg_t       cfg,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          red_in,
    input  logic [7:0]          green_in,
    input  logic [7:0]          blue_in,
    input  logic [7:0]          alpha_in,
    input  logic                full,
    output logic                push,
    output deg_pkg::item_t      item
);

    deg_pkg::pixel_t line_mem [0:deg_pkg::MAX_WIDTH-1];

    logic [deg_pkg::COL_W-1:0] col_reg, col_next;
    logic [deg_pkg::ROW_W-1:0] row_reg, row_next;
    deg_pkg::pixel_t           up_reg;
    deg_pkg::pixel_t           up_left_reg;
    deg_pkg::pixel_t           left_reg;

    logic                      accept;
    logic                      last_col;
    logic                      last_row;
    logic                      has_up;
    logic                      has_left;
    deg_pkg::pixel_t           px;
    logic [deg_pkg::COL_W-1:0] wr_addr;
    logic [deg_pkg::COL_W-1:0] rd_addr;

    assign in_stall = full;
    assign accept   = in_valid && !full;
    assign px       = {alpha_in, blue_in, green_in, red_in};
    assign last_col = col_reg >= cfg.col_last;
    assign last_row = row_reg >= cfg.row_last;
    assign has_up   = row_reg != '0;
    assign has_left = col_reg != '0;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    // one buffer: columns not yet reached in this row still hold the row
    // above; the read address runs one beat ahead so the data is ready
    assign wr_addr = col_reg;
    assign rd_addr = col_next;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            line_mem[wr_addr] <= px;
        end
        if (accept && (wr_addr == rd_addr))
        begin
            up_reg <= px;
        end
        else
        begin
            up_reg <= line_mem[rd_addr];
        end
        if (accept)
        begin
            up_left_reg <= up_reg;
            left_reg    <= px;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_comb
    begin
        item.px      = px;
        item.up_left = up_left_reg;
        item.up      = up_reg;
        item.left    = left_reg;
        item.col     = col_reg;
        item.row     = row_reg;
        item.mask    = '0;
        item.mask[deg_pkg::JOB_UP_LEFT] = has_up && has_left;
        item.mask[deg_pkg::JOB_UP]      = has_up && last_col;
        item.mask[deg_pkg::JOB_LEFT]    = last_row && has_left;
        item.mask[deg_pkg::JOB_SELF]    = last_row && last_col;
    end

    // pixels that release nothing are not queued
    assign push = accept && (item.mask != '0);

endmodule

// ===== hdl/deg_queue.sv =====
// Short queue of classified pixels between front and back end.
// Depends on deg_pkg.
`timescale 1ns / 1ps

module deg_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  deg_pkg::item_t push_item,
    input  logic           pop,
    output deg_pkg::item_t head,
    output logic           head_valid,
    output logic           full
);

    deg_pkg::item_t entry_reg [0:deg_pkg::QDEPTH-1];

    logic [deg_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [deg_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [deg_pkg::QPTR_W:0]   count_reg, count_next;

    assign head       = entry_reg[rd_ptr_reg];
    assign head_valid = count_reg != '0;
    assign full       = count_reg == (deg_pkg::QPTR_W + 1)'(deg_pkg::QDEPTH);

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hdl/deg_back.sv =====
// Back end: expands each queued pixel into its results, one per cycle unless stalled,
// through a two-stage emboss datapath ending in the output register. Depends on deg_pkg.
`timescale 1ns / 1ps

module deg_back
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  deg_pkg::cfg_t             cfg,
    input  deg_pkg::item_t            head,
    input  logic                      head_valid,
    output logic                      pop,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [deg_pkg::COL_W-1:0] out_col,
    output logic [deg_pkg::ROW_W-1:0] out_row,
    output logic [7:0]                gray_out,
    output logic [7:0]                alpha_out,
    output logic                      last_of_run
);

    // abs((own - nb) * f + 127); fits 14 bits for any 6-bit factor
    function automatic logic [13:0] chan_mag(input logic [7:0] own,
                                             input logic [7:0] nb,
                                             input logic [deg_pkg::F_W-1:0] f);
        logic signed [8:0]  diff;
        logic signed [16:0] v;
        logic [16:0]        mag;
        diff = $signed({1'b0, own}) - $signed({1'b0, nb});
        v    = 17'(diff) * 17'($signed({1'b0, f})) + 17'sd127;
        mag  = v[16] ? 17'(-v) : 17'(v);
        return mag[13:0];
    endfunction

    logic [deg_pkg::NJOB-1:0]  done_reg, done_next;
    logic [deg_pkg::NJOB-1:0]  rem;
    logic [deg_pkg::NJOB-1:0]  sel;
    logic                      advance;
    logic                      issue;
    logic                      job_last;
    deg_pkg::pixel_t           own;
    logic [deg_pkg::COL_W-1:0] job_col;
    logic [deg_pkg::ROW_W-1:0] job_row;
    logic [deg_pkg::SUM_W-1:0] job_sum;

    logic                      s1_valid_reg;
    logic [deg_pkg::COL_W-1:0] s1_col_reg;
    logic [deg_pkg::ROW_W-1:0] s1_row_reg;
    logic [deg_pkg::SUM_W-1:0] s1_sum_reg;
    logic [7:0]                s1_alpha_reg;
    logic                      s1_last_reg;

    logic                      out_valid_reg;
    logic [deg_pkg::COL_W-1:0] out_col_reg;
    logic [deg_pkg::ROW_W-1:0] out_row_reg;
    logic [7:0]                gray_reg;
    logic [7:0]                alpha_reg;
    logic                      last_reg;

    logic                      sat;
    logic [20:0]               quot_prod;
    logic [7:0]                gray_next;

    // whole pipeline moves together whenever the output register is free
    assign advance  = !out_valid_reg || !out_stall;
    assign issue    = head_valid && advance;
    assign rem      = head.mask & ~done_reg;
    assign sel      = rem & (~rem + 1'b1);
    assign job_last = (rem & ~sel) == '0;
    assign pop      = issue && job_last;

    always_comb
    begin
        done_next = done_reg;
        if (issue)
        begin
            done_next = job_last ? '0 : (done_reg | sel);
        end
    end

    always_comb
    begin
        own = head.px;
        if (sel[deg_pkg::JOB_UP_LEFT])
        begin
            own = head.up_left;
        end
        else if (sel[deg_pkg::JOB_UP])
        begin
            own = head.up;
        end
        else if (sel[deg_pkg::JOB_LEFT])
        begin
            own = head.left;
        end
        job_col = (sel[deg_pkg::JOB_UP_LEFT] || sel[deg_pkg::JOB_LEFT])
                  ? head.col - 1'b1 : head.col;
        job_row = (sel[deg_pkg::JOB_UP_LEFT] || sel[deg_pkg::JOB_UP])
                  ? head.row - 1'b1 : head.row;
        // the neighbour is always the pixel that just arrived
        job_sum = deg_pkg::SUM_W'(chan_mag(own[7:0],   head.px[7:0],   cfg.factor))
                + deg_pkg::SUM_W'(chan_mag(own[15:8],  head.px[15:8],  cfg.factor))
                + deg_pkg::SUM_W'(chan_mag(own[23:16], head.px[23:16], cfg.factor));
    end

    // sum / 3 by reciprocal; exact below 768, and 768 upwards clamps to 255
    assign sat       = s1_sum_reg >= deg_pkg::SUM_W'(3 * 256);
    assign quot_prod = 21'(s1_sum_reg[9:0]) * 21'd683;
    assign gray_next = sat ? 8'hFF : quot_prod[18:11];

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_col_reg   <= job_col;
            s1_row_reg   <= job_row;
            s1_sum_reg   <= job_sum;
            s1_alpha_reg <= own[31:24];
            s1_last_reg  <= job_last;
        end
        if (advance && s1_valid_reg)
        begin
            out_col_reg <= s1_col_reg;
            out_row_reg <= s1_row_reg;
            gray_reg    <= gray_next;
            alpha_reg   <= s1_alpha_reg;
            last_reg    <= s1_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
            if (advance)
            begin
                s1_valid_reg  <= issue;
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_col     = out_col_reg;
    assign out_row     = out_row_reg;
    assign gray_out    = gray_reg;
    assign alpha_out   = alpha_reg;
    assign last_of_run = last_reg;

endmodule

// ===== hdl/diagonal_emboss_gray_filter.sv =====
// Throughput: one pixel beat per cycle while the 4-entry queue has room; the
// back end delivers one result per cycle while out_stall is low, so pixels
// releasing several results (row and frame ends) set the sustained rate, about
// one pixel per cycle overall.
// Reset clears counters, queue, pipeline and loads default config; the line
// buffer is not cleared.
`timescale 1ns / 1ps

module diagonal_emboss_gray_filter
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [15:0]               cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                red_in,
    input  logic [7:0]                green_in,
    input  logic [7:0]                blue_in,
    input  logic [7:0]                alpha_in,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [deg_pkg::COL_W-1:0] out_col,
    output logic [deg_pkg::ROW_W-1:0] out_row,
    output logic [7:0]                gray_out,
    output logic [7:0]                alpha_out,
    output logic                      last_of_run
);

    logic [deg_pkg::F_W-1:0]   factor_reg, factor_next;
    logic [deg_pkg::COL_W-1:0] col_last_reg, col_last_next;
    logic [deg_pkg::ROW_W-1:0] row_last_reg, row_last_next;
    logic [deg_pkg::COL_W:0]   wr_width;
    deg_pkg::cfg_t             cfg;

    logic                      push;
    logic                      pop;
    logic                      full;
    logic                      head_valid;
    deg_pkg::item_t            push_item;
    deg_pkg::item_t            head;

    assign wr_width = cfg_data[deg_pkg::COL_W:0];

    // registers hold the derived values: factor and last column / row index
    always_comb
    begin
        factor_next   = factor_reg;
        col_last_next = col_last_reg;
        row_last_next = row_last_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                deg_pkg::REG_DEPTH:
                begin
                    factor_next = deg_pkg::F_W'((18'(cfg_data[8:0]) * 18'd205) >> 11);
                end
                deg_pkg::REG_WIDTH:
                begin
                    if (wr_width == '0)
                    begin
                        col_last_next = '0;
                    end
                    else if (wr_width > (deg_pkg::COL_W + 1)'(deg_pkg::MAX_WIDTH))
                    begin
                        col_last_next = deg_pkg::COL_W'(deg_pkg::MAX_WIDTH - 1);
                    end
                    else
                    begin
                        col_last_next = deg_pkg::COL_W'(wr_width - 1'b1);
                    end
                end
                deg_pkg::REG_HEIGHT:
                begin
                    row_last_next = (cfg_data == '0) ? '0 : cfg_data - 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg   <= deg_pkg::F_W'(deg_pkg::DEPTH_RESET / 10);
            col_last_reg <= deg_pkg::COL_W'(deg_pkg::WIDTH_RESET - 1);
            row_last_reg <= deg_pkg::ROW_W'(deg_pkg::HEIGHT_RESET - 1);
        end
        else
        begin
            factor_reg   <= factor_next;
            col_last_reg <= col_last_next;
            row_last_reg <= row_last_next;
        end
    end

    always_comb
    begin
        cfg.factor   = factor_reg;
        cfg.col_last = col_last_reg;
        cfg.row_last = row_last_reg;
    end

    deg_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .red_in   (red_in),
        .green_in (green_in),
        .blue_in  (blue_in),
        .alpha_in (alpha_in),
        .full     (full),
        .push     (push),
        .item     (push_item)
    );

    deg_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .full       (full)
    );

    deg_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .head        (head),
        .head_valid  (head_valid),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_col     (out_col),
        .out_row     (out_row),
        .gray_out    (gray_out),
        .alpha_out   (alpha_out),
        .last_of_run (last_of_run)
    );

endmodule

// ===== hdl/deg_checker.sv =====
// Port-level checks for diagonal_emboss_gray_filter, bound to the top level.
// Depends on deg_pkg and the top level's port list.
`timescale 1ns / 1ps

module deg_checker
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_stall,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic [deg_pkg::COL_W-1:0] out_col,
    input logic [deg_pkg::ROW_W-1:0] out_row,
    input logic [7:0]                gray_out,
    input logic [7:0]                alpha_out,
    input logic                      last_of_run
);

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_col) && $stable(out_row)
            && $stable(gray_out) && $stable(alpha_out) && $stable(last_of_run))
        else $error("stalled result beat changed");

    // the results of one pixel come out without gaps
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_run |=> out_valid)
        else $error("gap inside a run of results");

    assert property (@(posedge clk) $rose(rst_n) |-> !out_valid)
        else $error("result beat straight after reset");

    assert property (@(posedge clk) $rose(rst_n) |-> !in_stall)
        else $error("input stalled with empty queue after reset");

endmodule

bind diagonal_emboss_gray_filter deg_checker u_deg_checker (.*);

// ===== tb/diagonal_emboss_gray_filter_tb.sv =====
// Self-checking testbench for diagonal_emboss_gray_filter.
// Depends on deg_pkg and the block's RTL; carries its own line-buffer model of the filter.
`timescale 1ns / 1ps

module diagonal_emboss_gray_filter_tb;

    import deg_pkg::*;

    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;
    localparam int RANDOM_ITEMS   = 45;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [7:0]       gray;
        logic [7:0]       alpha;
        logic             last;
    } gray_result_t;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             cfg_we      = 1'b0;
    logic [1:0]       cfg_index   = '0;
    logic [15:0]      cfg_data    = '0;
    logic             in_valid    = 1'b0;
    logic             in_stall;
    logic [7:0]       red_in      = '0;
    logic [7:0]       green_in    = '0;
    logic [7:0]       blue_in     = '0;
    logic [7:0]       alpha_in    = '0;
    logic             out_valid;
    logic             out_stall   = 1'b0;
    logic [COL_W-1:0] out_col;
    logic [ROW_W-1:0] out_row;
    logic [7:0]       gray_out;
    logic [7:0]       alpha_out;
    logic             last_of_run;

    // filter model: registers, line buffers and raster position
    logic [8:0]  depth_reg  = 9'd30;
    logic [12:0] width_reg  = 13'd640;
    logic [15:0] height_reg = 16'd480;
    pixel_t      prev_row [MAX_WIDTH];
    pixel_t      cur_row [MAX_WIDTH];
    int          col_cnt = 0;
    int          row_cnt = 0;

    gray_result_t expected_q [$];
    gray_result_t exp_res;
    gray_result_t got_res;

    pixel_t last_px       = '0;
    int     send_idle_pct = 0;
    int     stall_pct     = 0;
    int     pixels_sent   = 0;
    int     results_seen  = 0;
    int     regs_written  = 0;
    int     mismatches    = 0;
    int     quiet_cycles  = 0;

    diagonal_emboss_gray_filter i_dut (.*);

    always
    begin
        #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // model
    // ------------------------------------------------------------------
    function automatic int eff_width();
        int w;
        w = width_reg;
        if (w < 1)
            w = 1;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        return w;
    endfunction

    function automatic logic [7:0] emboss_gray(input pixel_t own, input pixel_t nb);
        int f;
        int v;
        int sum;
        int k;
        f = int'(depth_reg) / 10;
        sum = 0;
        for (k = 0; k < 3; k++)
        begin
            v = (int'(own[8*k +: 8]) - int'(nb[8*k +: 8])) * f + 127;
            if (v < 0)
                v = -v;
            sum += v;
        end
        sum = sum / 3;
        if (sum > 255)
            sum = 255;
        return sum[7:0];
    endfunction

    function automatic gray_result_t make_result(input int col, input int row,
                                                 input pixel_t own, input pixel_t nb);
        gray_result_t res;
        res.col   = col[COL_W-1:0];
        res.row   = row[ROW_W-1:0];
        res.gray  = emboss_gray(own, nb);
        res.alpha = own[31:24];
        res.last  = 1'b0;
        return res;
    endfunction

    // Works out the results released by one accepted pixel and advances the model.
    task automatic predict_pixel(input pixel_t px);
        int           w;
        int           h;
        int           c;
        int           r;
        int           n;
        int           i;
        bit           lastc;
        bit           lastr;
        gray_result_t batch [4];
        w = eff_width();
        h = (height_reg == 16'd0) ? 1 : int'(height_reg);
        c = (col_cnt >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_cnt;
        r = row_cnt;
        // counts at or past the end (after a shrink) act as the last column / row
        lastc = (c >= w - 1);
        lastr = (r >= h - 1);
        n = 0;
        if (r >= 1 && c >= 1)
        begin
            batch[n] = make_result(c - 1, r - 1, prev_row[c - 1], px);
            n++;
        end
        if (r >= 1 && lastc)
        begin
            batch[n] = make_result(c, r - 1, prev_row[c], px);
            n++;
        end
        if (lastr && c >= 1)
        begin
            batch[n] = make_result(c - 1, r, cur_row[c - 1], px);
            n++;
        end
        if (lastr && lastc)
        begin
            batch[n] = make_result(c, r, px, px);
            n++;
        end
        for (i = 0; i < n; i++)
        begin
            if (i == n - 1)
                batch[i].last = 1'b1;
            expected_q = {expected_q, batch[i]};
        end
        cur_row[c] = px;
        if (lastc)
        begin
            for (i = 0; i < MAX_WIDTH; i++)
                prev_row[i] = cur_row[i];
            col_cnt = 0;
            row_cnt = lastr ? 0 : ((r + 1) & 16'hFFFF);
        end
        else
        begin
            col_cnt = c + 1;
        end
    endtask

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic send_pixel(input pixel_t px);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        red_in   <= px[7:0];
        green_in <= px[15:8];
        blue_in  <= px[23:16];
        alpha_in <= px[31:24];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_pixel(px);
        pixels_sent++;
        last_px = px;
    endtask

    // Holds the input off until every pending result is out, then lets the
    // pipeline settle in case the last beats released nothing.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_reg(input logic [1:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[15:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_DEPTH:  depth_reg  = value[8:0];
            REG_WIDTH:  width_reg  = value[12:0];
            REG_HEIGHT: height_reg = value[15:0];
            default: ;
        endcase
        regs_written++;
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        send_idle_pct = sender_pct;
        stall_pct     = receiver_pct;
    endtask

    function automatic pixel_t random_pixel();
        pixel_t px;
        int     k;
        px = $urandom;
        case ($urandom_range(3))
            0:
            begin
                for (k = 0; k < 4; k++)
                    px[8*k +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
            end
            1:
            begin
                // close to the previous pixel: small differences per channel
                for (k = 0; k < 3; k++)
                    px[8*k +: 8] = last_px[8*k +: 8] + 8'($urandom_range(8)) - 8'd4;
            end
            default: ;
        endcase
        return px;
    endfunction

    // ------------------------------------------------------------------
    // receiver, checker and watchdog
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic note_mismatch(input string what, input gray_result_t want,
                                 input gray_result_t got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t %s: want col %0d row %0d gray %0d alpha %0d last %0b",
                     $realtime, what, want.col, want.row, want.gray, want.alpha, want.last,
                     " / got col %0d row %0d gray %0d alpha %0d last %0b",
                     got.col, got.row, got.gray, got.alpha, got.last);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got_res.col   = out_col;
            got_res.row   = out_row;
            got_res.gray  = gray_out;
            got_res.alpha = alpha_out;
            got_res.last  = last_of_run;
            results_seen++;
            if (expected_q.size() == 0)
            begin
                note_mismatch("unexpected result beat", '0, got_res);
            end
            else
            begin
                exp_res = expected_q.pop_front();
                if (got_res.col !== exp_res.col || got_res.row !== exp_res.row ||
                    got_res.gray !== exp_res.gray || got_res.alpha !== exp_res.alpha ||
                    got_res.last !== exp_res.last)
                    note_mismatch("result mismatch", exp_res, got_res);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t watchdog: no beat for %0d cycles", $realtime, quiet_cycles);
            $display("tb: failure");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // Defaults (depth 30, 640 x 480) for a few beats of the first row, then a
    // width shrink below the current column and a height shrink below the
    // current row.
    task automatic test_reset_defaults();
        repeat (3) send_pixel($urandom);
        drain_results();
        set_reg(REG_WIDTH, 2);
        repeat (3) send_pixel($urandom);
        drain_results();
        set_reg(REG_HEIGHT, 2);
        send_pixel($urandom);
        send_pixel($urandom);
    endtask

    task automatic test_pixel_extremes();
        drain_results();
        set_reg(REG_DEPTH, 300);
        set_reg(REG_WIDTH, 3);
        set_reg(REG_HEIGHT, 2);
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h55AA_55AA);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h0000_0000);
        send_pixel(32'hAA55_AA55);
    endtask

    // below ten the factor is zero; 511 gives the largest factor
    task automatic test_depth_settings();
        int depths [5] = '{0, 9, 10, 19, 511};
        int i;
        drain_results();
        set_reg(REG_WIDTH, 2);
        set_reg(REG_HEIGHT, 2);
        for (i = 0; i < 5; i++)
        begin
            drain_results();
            set_reg(REG_DEPTH, depths[i]);
            send_pixel(32'hFF00_FF00);
            send_pixel(32'h00FF_00FF);
            send_pixel(32'h00FF_FF00);
            send_pixel(32'hFFFF_FFFF);
        end
    endtask

    // zero width and height act as one
    task automatic test_degenerate_geometry();
        drain_results();
        set_reg(REG_DEPTH, 30);
        set_reg(REG_WIDTH, 0);
        set_reg(REG_HEIGHT, 0);
        repeat (3) send_pixel(random_pixel());
        drain_results();
        set_reg(REG_WIDTH, 1);
        set_reg(REG_HEIGHT, 3);
        repeat (3) send_pixel(random_pixel());
        drain_results();
        set_reg(REG_WIDTH, 5);
        set_reg(REG_HEIGHT, 0);
        repeat (5) send_pixel(random_pixel());
    endtask

    // tallest frame, cut short once two rows are in
    task automatic test_tall_frame_cut_short();
        drain_results();
        set_reg(REG_DEPTH, 55);
        set_reg(REG_WIDTH, 2);
        set_reg(REG_HEIGHT, 65535);
        repeat (4) send_pixel(random_pixel());
        drain_results();
        set_reg(REG_HEIGHT, 1);
        repeat (2) send_pixel(random_pixel());
    endtask

    // over-range and full widths on a single row, cut short by a narrow width
    task automatic test_widest_rows();
        drain_results();
        set_reg(REG_WIDTH, 8191);
        set_reg(REG_HEIGHT, 1);
        repeat (4) send_pixel(random_pixel());
        drain_results();
        set_reg(REG_WIDTH, MAX_WIDTH);
        repeat (2) send_pixel(random_pixel());
        drain_results();
        set_reg(REG_WIDTH, 3);
        send_pixel(random_pixel());
    endtask

    // Small random frames; now and then the flow is drained mid-frame and the
    // depth, the height or a width no wider than the current one is written.
    task automatic test_random_frames(input int target);
        int start;
        int pick;
        int w;
        start = pixels_sent;
        while (pixels_sent - start < target)
        begin
            drain_results();
            pick = $urandom_range(19);
            if (pick < 15)
                w = $urandom_range(8, 1);
            else if (pick < 18)
                w = $urandom_range(24, 9);
            else
                w = pick - 18;
            set_reg(REG_DEPTH, ($urandom_range(3) == 0) ? $urandom_range(511)
                                                        : $urandom_range(300, 10));
            set_reg(REG_WIDTH, w);
            set_reg(REG_HEIGHT, $urandom_range(4, 0));
            do
            begin
                if ($urandom_range(24) == 0)
                begin
                    drain_results();
                    case ($urandom_range(2))
                        0:       set_reg(REG_DEPTH, $urandom_range(511));
                        1:       set_reg(REG_HEIGHT, $urandom_range(5, 0));
                        // growing the width mid-frame would read unwritten buffer
                        default: set_reg(REG_WIDTH, $urandom_range(eff_width(), 1));
                    endcase
                end
                send_pixel(random_pixel());
            end
            while (col_cnt != 0 || row_cnt != 0);
        end
    endtask

    initial
    begin
        set_idling(18, 80);
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_pixel_extremes();
        test_depth_settings();
        test_degenerate_geometry();
        test_tall_frame_cut_short();
        test_widest_rows();
        test_random_frames(RANDOM_ITEMS);
        set_idling(80, 18);
        test_random_frames(RANDOM_ITEMS);
        set_idling(0, 0);
        test_random_frames(RANDOM_ITEMS);

        drain_results();
        repeat (20) @(posedge clk);
        $display("summary: %0d pixel beats in, %0d result beats checked, %0d register writes",
                 pixels_sent, results_seen, regs_written);
        $display("summary: depth, width and height extremes, mid-frame shrinks, %0d mismatches",
                 mismatches);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
